/* design/nma_pkg.sv */
// ----------------------------------------------------------------------------
// nma_pkg: shared types, constants and activation tables
// Widths, fixed-point format, configuration codes and the sigmoid and tanh
// lookup tables that are built once at elaboration.
// ----------------------------------------------------------------------------
package nma_pkg;

  // Fixed-point format and datapath widths.
  localparam int TableBits = 10;
  localparam int FracBits  = 12;
  localparam int DataW     = 16;
  localparam int ProdW     = 2 * DataW;
  localparam int AccW      = 40;
  localparam int RomDepth  = 1 << TableBits;
  localparam int RomShift  = DataW - TableBits;
  localparam int CfgIdxW   = 1;
  localparam int ModeW     = 3;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [DataW-1:0] DataMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] DataMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] OneQ = DataW'(1 << FracBits);

  // Activation select codes; codes above ACT_STEP give a zero result.
  typedef enum logic [ModeW-1:0] {
    ACT_SIGMOID  = 3'd0,
    ACT_TANH     = 3'd1,
    ACT_RELU     = 3'd2,
    ACT_IDENTITY = 3'd3,
    ACT_STEP     = 3'd4
  } act_mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIAS = 1'b0,
    CFG_MODE = 1'b1
  } cfg_idx_e;

  localparam logic signed [DataW-1:0] BiasReset = DataW'(4096);
  localparam logic [ModeW-1:0]        ModeReset = ACT_TANH;

  // One product term on its way from the front end to the accumulator.
  typedef struct packed {
    logic signed [ProdW-1:0] prod;
    logic                    last;
  } term_t;

  // Live configuration seen by the back end.
  typedef struct packed {
    logic signed [DataW-1:0] bias;
    logic [ModeW-1:0]        mode;
  } cfg_t;

  typedef logic [DataW-1:0] rom_t [RomDepth];

  localparam logic [63:0] Q30One = 64'd1 << 30;

  // Restoring division, used only while the tables are built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^f for 0 <= f <= 1.0 in Q.30, by a series through the twentieth power.
  function automatic logic [63:0] exp_pos_q30(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q30One;
    term = Q30One;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * f) >> 30, 64'(k));
      sum  = sum + term;
    end
    return sum;
  endfunction

  // e^-a for a >= 0 given in the data format; result in Q.30.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
    logic [63:0] n;
    logic [63:0] frac;
    logic [63:0] e;
    logic [63:0] einv;
    n    = a >> FracBits;
    frac = a & ((64'd1 << FracBits) - 64'd1);
    e    = udiv64(64'd1 << 60, exp_pos_q30(frac << (30 - FracBits)));
    einv = udiv64(64'd1 << 60, exp_pos_q30(Q30One));
    while (n > 0 && e != 0) begin
      e = (e * einv) >> 30;
      n = n - 64'd1;
    end
    return e;
  endfunction

  // Lower edge of table bin idx, sign extended.
  function automatic longint bin_edge(input int idx);
    logic signed [DataW-1:0] xs;
    xs = DataW'(idx);
    xs = xs << RomShift;
    return longint'(xs);
  endfunction

  function automatic rom_t build_sigmoid();
    rom_t        rom;
    longint      x;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    for (int i = 0; i < RomDepth; i++) begin
      x   = bin_edge(i);
      a   = (x < 0) ? 64'(-x) : 64'(x);
      e   = exp_neg_q30(a);
      den = Q30One + e;
      num = ((x >= 0) ? Q30One : e) << FracBits;
      rom[i] = DataW'(udiv64(num + (den >> 1), den));
    end
    return rom;
  endfunction

  function automatic rom_t build_tanh();
    rom_t        rom;
    longint      x;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] r;
    for (int i = 0; i < RomDepth; i++) begin
      x   = bin_edge(i);
      a   = 64'd2 * ((x < 0) ? 64'(-x) : 64'(x));
      e   = exp_neg_q30(a);
      den = Q30One + e;
      num = (Q30One - e) << FracBits;
      r   = udiv64(num + (den >> 1), den);
      rom[i] = (x < 0) ? DataW'(-r) : DataW'(r);
    end
    return rom;
  endfunction

  localparam rom_t SigmoidRom = build_sigmoid();
  localparam rom_t TanhRom    = build_tanh();

endpackage

/* design/nma_front.sv */
// ----------------------------------------------------------------------------
// nma_front: input stage
// Takes input transfers, forms the product of sample and weight, and holds
// the term until the term queue takes it.
// ----------------------------------------------------------------------------
module nma_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [nma_pkg::ProdW-1:0]     s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          term_valid_o,
  input  logic                          term_ready_i,
  output nma_pkg::term_t                term_o
);

  logic                 valid_q, valid_d;
  nma_pkg::term_t       term_q, term_d;
  logic                 take;
  logic signed [nma_pkg::DataW-1:0] value;
  logic signed [nma_pkg::DataW-1:0] weight;

  assign value  = s_axis_tdata[nma_pkg::DataW-1:0];
  assign weight = s_axis_tdata[nma_pkg::ProdW-1:nma_pkg::DataW];

  // The slot is free when empty or when its term leaves this cycle.
  assign s_axis_tready = !valid_q || term_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  // Product and last flag are captured on each input transfer.
  always_comb begin
    valid_d = valid_q;
    term_d  = term_q;
    if (take) begin
      valid_d     = 1'b1;
      term_d.prod = value * weight;
      term_d.last = s_axis_tlast;
    end else if (term_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign term_valid_o = valid_q;
  assign term_o       = term_q;

endmodule

/* design/nma_fifo.sv */
// ----------------------------------------------------------------------------
// nma_fifo: term queue
// Four-entry queue that decouples the front end from the accumulator.
// ----------------------------------------------------------------------------
module nma_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nma_pkg::term_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output nma_pkg::term_t  head_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  nma_pkg::term_t     mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]      count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == (PtrW + 1)'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/nma_back.sv */
// ----------------------------------------------------------------------------
// nma_back: accumulate and activate
// Drains the term queue into the saturating accumulator. A last term closes
// the sum, which is rounded, biased, clamped and passed through the selected
// activation into the output register.
// ----------------------------------------------------------------------------
module nma_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nma_pkg::cfg_t                  cfg_i,
  input  logic                           empty_i,
  input  nma_pkg::term_t                 head_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [nma_pkg::ProdW-1:0]      m_axis_tdata,
  output logic                           m_axis_tuser
);

  localparam int QW   = nma_pkg::AccW + 1 - nma_pkg::FracBits;
  localparam int PreW = QW + 1;

  // Accumulator state.
  logic signed [nma_pkg::AccW-1:0] acc_q, acc_d;
  logic                            clip_seen_q, clip_seen_d;

  // Closed sum waiting for rounding.
  logic                            s1_valid_q, s1_valid_d;
  logic signed [nma_pkg::AccW-1:0] s1_acc_q;
  logic                            s1_clip_q;

  // Clamped pre-activation waiting for the activation.
  logic                             s2_valid_q, s2_valid_d;
  logic signed [nma_pkg::DataW-1:0] s2_pre_q, s2_pre_d;
  logic                             s2_clip_q, s2_clip_d;

  // Output register.
  logic                             out_valid_q, out_valid_d;
  logic signed [nma_pkg::DataW-1:0] out_act_q, out_act_d;
  logic signed [nma_pkg::DataW-1:0] out_pre_q;
  logic                             out_clip_q;

  logic out_free, s2_adv, s2_free, s1_adv, s1_free;
  logic signed [nma_pkg::AccW:0]   acc_sum;
  logic signed [nma_pkg::AccW-1:0] acc_sat;
  logic                            acc_ovf;
  logic signed [nma_pkg::AccW:0]   rnd_sum;
  logic signed [QW-1:0]            q_val;
  logic signed [PreW-1:0]          pre_wide;
  logic [nma_pkg::TableBits-1:0]   rom_idx;

  // Stall chain from the output back to the queue head.
  assign out_free = !out_valid_q || m_axis_tready;
  assign s2_adv   = s2_valid_q && out_free;
  assign s2_free  = !s2_valid_q || s2_adv;
  assign s1_adv   = s1_valid_q && s2_free;
  assign s1_free  = !s1_valid_q || s1_adv;
  assign pop_o    = !empty_i && (!head_i.last || s1_free);

  // Saturating accumulate of the head term.
  always_comb begin
    acc_sum = {acc_q[nma_pkg::AccW-1], acc_q} + (nma_pkg::AccW + 1)'(head_i.prod);
    acc_ovf = 1'b0;
    acc_sat = acc_sum[nma_pkg::AccW-1:0];
    if (acc_sum > (nma_pkg::AccW + 1)'(nma_pkg::AccMax)) begin
      acc_sat = nma_pkg::AccMax;
      acc_ovf = 1'b1;
    end else if (acc_sum < (nma_pkg::AccW + 1)'(nma_pkg::AccMin)) begin
      acc_sat = nma_pkg::AccMin;
      acc_ovf = 1'b1;
    end
  end

  // A last term hands the closed sum on and clears the accumulator.
  always_comb begin
    acc_d       = acc_q;
    clip_seen_d = clip_seen_q;
    s1_valid_d  = s1_adv ? 1'b0 : s1_valid_q;
    if (pop_o) begin
      if (head_i.last) begin
        acc_d       = '0;
        clip_seen_d = 1'b0;
        s1_valid_d  = 1'b1;
      end else begin
        acc_d       = acc_sat;
        clip_seen_d = clip_seen_q || acc_ovf;
      end
    end
  end

  // Round half up back to the data format, add bias, clamp.
  always_comb begin
    rnd_sum   = (nma_pkg::AccW + 1)'(s1_acc_q)
              + (nma_pkg::AccW + 1)'(1 << (nma_pkg::FracBits - 1));
    q_val     = QW'(rnd_sum >>> nma_pkg::FracBits);
    pre_wide  = PreW'(q_val) + PreW'(cfg_i.bias);
    s2_pre_d  = pre_wide[nma_pkg::DataW-1:0];
    s2_clip_d = s1_clip_q;
    if (pre_wide > PreW'(nma_pkg::DataMax)) begin
      s2_pre_d  = nma_pkg::DataMax;
      s2_clip_d = 1'b1;
    end else if (pre_wide < PreW'(nma_pkg::DataMin)) begin
      s2_pre_d  = nma_pkg::DataMin;
      s2_clip_d = 1'b1;
    end
    s2_valid_d = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_q);
  end

  // Activation select; table entries sit at the lower edge of each bin.
  assign rom_idx = s2_pre_q[nma_pkg::DataW-1 -: nma_pkg::TableBits];

  always_comb begin
    case (nma_pkg::act_mode_e'(cfg_i.mode))
      nma_pkg::ACT_SIGMOID:  out_act_d = nma_pkg::SigmoidRom[rom_idx];
      nma_pkg::ACT_TANH:     out_act_d = nma_pkg::TanhRom[rom_idx];
      nma_pkg::ACT_RELU:     out_act_d = s2_pre_q[nma_pkg::DataW-1] ? '0 : s2_pre_q;
      nma_pkg::ACT_IDENTITY: out_act_d = s2_pre_q;
      nma_pkg::ACT_STEP:     out_act_d = (s2_pre_q > 0) ? nma_pkg::OneQ : '0;
      default:               out_act_d = '0;
    endcase
    out_valid_d = s2_adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      clip_seen_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      clip_seen_q <= clip_seen_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only when their stage takes a new item.
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      s1_acc_q  <= acc_sat;
      s1_clip_q <= clip_seen_q || acc_ovf;
    end
    if (s1_adv) begin
      s2_pre_q  <= s2_pre_d;
      s2_clip_q <= s2_clip_d;
    end
    if (s2_adv) begin
      out_act_q  <= out_act_d;
      out_pre_q  <= s2_pre_q;
      out_clip_q <= s2_clip_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pre_q, out_act_q};
  assign m_axis_tuser  = out_clip_q;

endmodule

/* design/neuron_mac_activation.sv */
// Path: a last term passes through the product, queue, close, round and
//   activate registers on its way to m_axis.
// Throughput: one term per cycle unless the queue fills or the output stalls;
//   one multiplier and one 40-bit accumulate stage each take a term per cycle.
// Reset: rst_ni clears the accumulator, queue and stage valids at once;
//   bias returns to 1.0 and the activation to tanh.
// ----------------------------------------------------------------------------
// neuron_mac_activation: one neuron, weighted sum and activation
// Holds the configuration registers and joins the front end, term queue
// and accumulate/activate back end.
// ----------------------------------------------------------------------------
module neuron_mac_activation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nma_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [nma_pkg::DataW-1:0]       cfg_data_i,
  // Input terms.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [nma_pkg::ProdW-1:0]       s_axis_tdata,  // in_value, in_weight
  input  logic                            s_axis_tlast,  // is_last
  // Results.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [nma_pkg::ProdW-1:0]       m_axis_tdata,  // activated, pre_activation
  output logic                            m_axis_tuser   // clipped
);

  logic signed [nma_pkg::DataW-1:0] bias_q, bias_d;
  logic [nma_pkg::ModeW-1:0]        mode_q, mode_d;
  nma_pkg::cfg_t                    cfg;
  nma_pkg::term_t                   front_term;
  nma_pkg::term_t                   head;
  logic                             front_valid;
  logic                             fifo_full;
  logic                             fifo_empty;
  logic                             pop;
  logic                             cfg_take;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_take    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    bias_d = bias_q;
    mode_d = mode_q;
    if (cfg_take) begin
      case (nma_pkg::cfg_idx_e'(cfg_index_i))
        nma_pkg::CFG_BIAS: bias_d = cfg_data_i;
        nma_pkg::CFG_MODE: mode_d = cfg_data_i[nma_pkg::ModeW-1:0];
        default:           bias_d = bias_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= nma_pkg::BiasReset;
      mode_q <= nma_pkg::ModeReset;
    end else begin
      bias_q <= bias_d;
      mode_q <= mode_d;
    end
  end

  assign cfg.bias = bias_q;
  assign cfg.mode = mode_q;

  nma_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .term_valid_o  (front_valid),
    .term_ready_i  (!fifo_full),
    .term_o        (front_term)
  );

  nma_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_term),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .head_o      (head)
  );

  nma_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .empty_i       (fifo_empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* design/nma_checker.sv */
// ----------------------------------------------------------------------------
// nma_checker: port-level checks
// Tracks the activation setting from configuration transfers and checks
// results against it, plus output stability under backpressure.
// ----------------------------------------------------------------------------
module nma_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [nma_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [nma_pkg::DataW-1:0]       cfg_data_i,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [nma_pkg::ProdW-1:0]       m_axis_tdata,
  input  logic                            m_axis_tuser
);

  logic [nma_pkg::ModeW-1:0]        mode_q, mode_d;
  logic signed [nma_pkg::DataW-1:0] act;
  logic signed [nma_pkg::DataW-1:0] pre;

  assign act = m_axis_tdata[nma_pkg::DataW-1:0];
  assign pre = m_axis_tdata[nma_pkg::ProdW-1:nma_pkg::DataW];

  // Shadow copy of the activation setting.
  always_comb begin
    mode_d = mode_q;
    if (cfg_valid_i && cfg_ready_o &&
        (cfg_index_i == nma_pkg::CfgIdxW'(nma_pkg::CFG_MODE))) begin
      mode_d = cfg_data_i[nma_pkg::ModeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= nma_pkg::ModeReset;
    end else begin
      mode_q <= mode_d;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // ReLU never gives a negative result.
  a_relu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_q == nma_pkg::ModeW'(nma_pkg::ACT_RELU)) |->
      !act[nma_pkg::DataW-1])
    else $error("negative ReLU result");

  // Identity passes the clamped sum through.
  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_q == nma_pkg::ModeW'(nma_pkg::ACT_IDENTITY)) |->
      act == pre)
    else $error("identity result differs from sum");

  // Step gives zero or one, one only for a positive sum.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_q == nma_pkg::ModeW'(nma_pkg::ACT_STEP)) |->
      ((pre > 0) && (act == nma_pkg::OneQ)) || (!(pre > 0) && (act == '0)))
    else $error("bad step result");

endmodule

bind neuron_mac_activation nma_checker u_nma_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for neuron_mac_activation
// Streams weighted terms with random frame lengths and handshake gaps, walks
// through bias and activation settings, and compares every result against
// an in-bench fixed-point predictor with its own sigmoid and tanh tables.
// ----------------------------------------------------------------------------
module testbench;
  import nma_pkg::*;

  // Predictor constants, kept local to the bench.
  localparam longint AccTop = (64'sd1 <<< (AccW - 1)) - 64'sd1;
  localparam longint AccBot = -(64'sd1 <<< (AccW - 1));
  localparam longint unsigned QOne30 = 64'd1 << 30;
  localparam int LutDepth = 1 << TableBits;
  localparam logic signed [DataW-1:0] UnitQ = DataW'(1 << FracBits);
  localparam logic [ModeW-1:0] ModeUnused = 3'd7;
  localparam int HoldCycles = 400;
  localparam int DrainLimit = 5000;
  localparam int PipeSettle = 20;

  // One expected result item.
  typedef struct {
    logic signed [DataW-1:0] act;
    logic signed [DataW-1:0] pre;
    logic                    clip;
  } neuron_out_t;

  // Predicts the neuron output and checks each result transfer in order.
  class neuron_result_board;
    longint                  acc;
    bit                      acc_clipped;
    logic signed [DataW-1:0] bias;
    logic [ModeW-1:0]        mode;
    logic [DataW-1:0]        sig_lut[LutDepth];
    logic [DataW-1:0]        tanh_lut[LutDepth];
    neuron_out_t             pending_results[$];
    int                      errors;

    // e^f for 0 <= f <= 1.0 in Q.30, series terms through the twentieth power.
    function longint unsigned q30_series(longint unsigned f);
      longint unsigned s;
      longint unsigned t;
      s = QOne30;
      t = QOne30;
      for (int k = 1; k <= 20; k++) begin
        t = ((t * f) >> 30) / longint'(k);
        s = s + t;
      end
      return s;
    endfunction

    // e^-a for a >= 0 in the data format; result in Q.30.
    function longint unsigned q30_decay(longint unsigned a);
      longint unsigned whole;
      longint unsigned e;
      longint unsigned einv;
      whole = a >> FracBits;
      e     = (64'd1 << 60) / q30_series((a & ((64'd1 << FracBits) - 1)) << (30 - FracBits));
      einv  = (64'd1 << 60) / q30_series(QOne30);
      while (whole > 0 && e != 0) begin
        e     = (e * einv) >> 30;
        whole = whole - 1;
      end
      return e;
    endfunction

    // Build both tables at the lower edge of each bin.
    function new();
      logic signed [DataW-1:0] bin_lo;
      longint                  x;
      longint unsigned         mag;
      longint unsigned         e;
      longint unsigned         den;
      longint unsigned         num;
      longint unsigned         r;
      for (int i = 0; i < LutDepth; i++) begin
        bin_lo = DataW'(i << (DataW - TableBits));
        x      = longint'(bin_lo);
        mag    = (x < 0) ? -x : x;
        e      = q30_decay(mag);
        den    = QOne30 + e;
        num    = ((x >= 0) ? QOne30 : e) << FracBits;
        sig_lut[i] = DataW'((num + den / 2) / den);
        e      = q30_decay(2 * mag);
        den    = QOne30 + e;
        num    = (QOne30 - e) << FracBits;
        r      = (num + den / 2) / den;
        tanh_lut[i] = (x < 0) ? DataW'(-r) : DataW'(r);
      end
      acc         = 0;
      acc_clipped = 1'b0;
      bias        = 16'sd4096;
      mode        = ACT_TANH;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [DataW-1:0] val);
      if (idx == CFG_BIAS) begin
        bias = val;
      end else begin
        mode = val[ModeW-1:0];
      end
    endfunction

    // Accumulate one accepted term; a last term closes the sum.
    function void take_term(logic signed [DataW-1:0] v, logic signed [DataW-1:0] w, bit last);
      longint                  q;
      longint                  pre_l;
      logic signed [DataW-1:0] pre;
      logic signed [DataW-1:0] act;
      bit                      clip;
      neuron_out_t             r;
      acc = acc + longint'(v) * longint'(w);
      if (acc > AccTop) begin
        acc = AccTop;
        acc_clipped = 1'b1;
      end
      if (acc < AccBot) begin
        acc = AccBot;
        acc_clipped = 1'b1;
      end
      if (!last) return;
      // Round half up back to the data format, then add the bias.
      q     = (acc + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      pre_l = q + longint'(bias);
      clip  = acc_clipped;
      if (pre_l > 32767) begin
        pre_l = 32767;
        clip  = 1'b1;
      end
      if (pre_l < -32768) begin
        pre_l = -32768;
        clip  = 1'b1;
      end
      pre = pre_l[DataW-1:0];
      case (mode)
        ACT_SIGMOID:  act = sig_lut[pre[DataW-1 -: TableBits]];
        ACT_TANH:     act = tanh_lut[pre[DataW-1 -: TableBits]];
        ACT_RELU:     act = (pre < 0) ? 16'sd0 : pre;
        ACT_IDENTITY: act = pre;
        ACT_STEP:     act = (pre > 0) ? UnitQ : 16'sd0;
        default:      act = 16'sd0;
      endcase
      r.act  = act;
      r.pre  = pre;
      r.clip = clip;
      pending_results.push_back(r);
      acc         = 0;
      acc_clipped = 1'b0;
    endfunction

    function void check_result(logic signed [DataW-1:0] act, logic signed [DataW-1:0] pre,
                               logic clip);
      neuron_out_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (act !== want.act) begin
        $error("activated: expected %0d, got %0d", want.act, act);
        errors++;
      end
      if (pre !== want.pre) begin
        $error("pre_activation: expected %0d, got %0d", want.pre, pre);
        errors++;
      end
      if (clip !== want.clip) begin
        $error("clipped: expected %0d, got %0d", want.clip, clip);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void report_leftover();
      if (pending_results.size() != 0) begin
        $error("%0d expected results never arrived", pending_results.size());
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [DataW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ProdW-1:0]    s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ProdW-1:0]    m_axis_tdata;
  logic                m_axis_tuser;

  neuron_result_board  board;
  bit                  src_calm = 1'b0;
  bit                  sink_calm = 1'b0;
  bit                  squeeze_go = 1'b0;

  neuron_mac_activation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // in_value, in_weight
    .s_axis_tlast  (s_axis_tlast),   // is_last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // activated, pre_activation
    .m_axis_tuser  (m_axis_tuser)    // clipped
  );

  always #2 clk_i = ~clk_i;

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : sink_ctrl
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (squeeze_go) begin
        hold_left  = HoldCycles;
        squeeze_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Signals are stable at the falling edge; a transfer seen here completes
  // at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result($signed(m_axis_tdata[DataW-1:0]),
                         $signed(m_axis_tdata[ProdW-1:DataW]), m_axis_tuser);
    end
  end

  task automatic send_term(logic signed [DataW-1:0] v, logic signed [DataW-1:0] w, bit last);
    bit ok;
    if (!src_calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, v};
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    board.take_term(v, w, last);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DataW-1:0] val);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    board.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected result, then let trailing terms clear the pipe.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < DrainLimit && board.pending() != 0; i++) @(posedge clk_i);
    repeat (PipeSettle) @(posedge clk_i);
  endtask

  // Operands: mostly moderate so sums stay in range, some full scale.
  function automatic logic signed [DataW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return DataMin;
          1:       return DataMax;
          2:       return 16'sd0;
          3:       return 16'sd1;
          default: return -16'sd1;
        endcase
      end
      1, 2:    return DataW'($urandom);
      default: return DataW'(int'($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  function automatic logic [ModeW-1:0] pick_mode();
    if ($urandom_range(0, 9) == 0) return ModeW'($urandom_range(5, 7));
    return ModeW'($urandom_range(ACT_SIGMOID, ACT_STEP));
  endfunction

  task automatic random_frames(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) send_term(pick_operand(), pick_operand(), i == len - 1);
      sent += len;
    end
  endtask

  // One setting: write both registers, optional threshold probes, random frames.
  task automatic run_phase(logic [DataW-1:0] bias, logic [ModeW-1:0] mode, int count,
                           bit probe);
    write_reg(CFG_BIAS, bias);
    write_reg(CFG_MODE, mode);
    if (probe) begin
      send_term(16'sd0, 16'sd0, 1'b1);
      send_term(16'sd1, 16'sd4096, 1'b1);
      send_term(-16'sd1, 16'sd4096, 1'b1);
    end
    random_frames(count);
    settle();
  endtask

  // A long run of one term drives the accumulator into its clamp.
  task automatic clamp_run(logic signed [DataW-1:0] v, logic signed [DataW-1:0] w, int count,
                           logic signed [DataW-1:0] lv, logic signed [DataW-1:0] lw);
    for (int i = 0; i < count; i++) send_term(v, w, 1'b0);
    send_term(lv, lw, 1'b1);
  endtask

  initial begin : stimulus
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings (tanh, bias 1.0): extremes, saturation and rounding.
    send_term(16'sd0, 16'sd0, 1'b1);
    send_term(DataMax, DataMax, 1'b1);
    send_term(DataMin, DataMin, 1'b1);
    send_term(DataMin, DataMax, 1'b1);
    send_term(DataMax, DataMin, 1'b1);
    send_term(16'sd4096, 16'sd4096, 1'b0);
    send_term(16'sd4096, -16'sd4096, 1'b1);
    send_term(16'sd1, 16'sd2048, 1'b1);    // exactly half: rounds up
    send_term(-16'sd1, 16'sd2048, 1'b1);   // minus half: rounds toward zero
    send_term(-16'sd1, 16'sd2049, 1'b1);
    send_term(-16'sd4096, 16'sd4096, 1'b1);
    settle();

    // Step, ReLU, sigmoid and tanh, with the bias extremes among the settings.
    run_phase(16'd0, ACT_STEP, 80, 1'b1);
    run_phase(16'd0, ACT_RELU, 80, 1'b1);
    run_phase(16'h8000, ACT_SIGMOID, 80, 1'b0);
    run_phase(16'h7FFF, ACT_TANH, 80, 1'b0);

    // Identity, including both accumulator clamps and a recovery term.
    write_reg(CFG_BIAS, DataW'($urandom));
    write_reg(CFG_MODE, ACT_IDENTITY);
    random_frames(40);
    clamp_run(DataMin, DataMin, 515, DataMin, DataMax);
    clamp_run(DataMin, DataMax, 520, DataMax, DataMax);
    random_frames(40);
    settle();

    // Undefined activation code.
    run_phase(DataW'($urandom), ModeUnused, 60, 1'b0);

    // Backpressure: output held off while single-term frames keep coming.
    write_reg(CFG_BIAS, DataW'($urandom));
    write_reg(CFG_MODE, ACT_SIGMOID);
    src_calm   = 1'b1;
    squeeze_go = 1'b1;
    for (int i = 0; i < 150; i++) send_term(pick_operand(), pick_operand(), 1'b1);
    src_calm = 1'b0;
    settle();

    // Random settings.
    for (int p = 0; p < 3; p++) run_phase(DataW'($urandom), pick_mode(), 40, 1'b0);

    // Closing stretch at full rate on both sides.
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    run_phase(DataW'($urandom), pick_mode(), 150, 1'b0);

    board.report_leftover();
    if (board.errors == 0) begin
      $display("neuron_mac_activation test passed");
    end else begin
      $display("neuron_mac_activation test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("neuron_mac_activation test failed");
    $finish;
  end

endmodule
